>>> hw/rtl/assert_macros.svh
// Assertion macros used by the back end of the block recycler.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: invariant");

// Antecedent implies consequent on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

`endif

>>> hw/rtl/abrsf_pkg.sv
// Package of the block recycler: default sizes, event codes, register indices,
// command and result flag types. No dependencies.
package abrsf_pkg;

	localparam int MAX_BLOCKS_DEF = 32;
	localparam int ID_BITS_DEF    = 8;

	localparam int NB_W      = 6;   // playback depth register
	localparam int SID_W     = 8;   // silent_block_id register
	localparam int POOLED_W  = 6;   // pooled_count result field

	localparam int CMD_DEPTH = 2;   // front-to-back queue
	localparam int RES_DEPTH = 2;   // result queue

	// configuration register indices
	localparam logic REG_DEPTH     = 1'b0;
	localparam logic REG_SILENT_ID = 1'b1;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_COMPLETE = 2'd1,
		OP_STOP     = 2'd2,
		OP_NONE     = 2'd3
	} op_e_t;

	typedef struct packed {
		op_e_t op;
		logic  has;
		logic  acc;
	} cmd_t;

	typedef struct packed {
		logic release_valid;
		logic submit_valid;
		logic submit_silent;
		logic took_producer;
		logic took_pool;
		logic wait_hint;
		logic clear_device;
		logic queue_error;
		logic last;
	} flags_t;

endpackage

>>> hw/rtl/abrsf_res_fifo.sv
// Result queue of the block recycler: small register FIFO with empty/pop on the read side.
// Depends on abrsf_pkg (RES_DEPTH).
module abrsf_res_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             empty,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data
);
	import abrsf_pkg::*;

	localparam int IDX_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	logic [WIDTH-1:0] ent_q [RES_DEPTH];
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             wr, rd;

	assign wr_ready = int'(count_q) != RES_DEPTH;
	assign empty    = count_q == '0;
	assign wr       = wr_valid && wr_ready;
	assign rd       = pop && !empty;
	assign rd_data  = ent_q[head_q];

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
		if (int'(p) == RES_DEPTH - 1) return '0;
		return IDX_W'(int'(p) + 1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr) ent_q[tail_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) tail_q <= nxt(tail_q);
			if (rd) head_q <= nxt(head_q);
			if (wr && !rd) count_q <= count_q + CNT_W'(1);
			else if (rd && !wr) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> hw/rtl/abrsf_front.sv
// Front end of the block recycler: takes requests, classifies the event, queues commands.
// Depends on abrsf_pkg (op_e_t, cmd_t, CMD_DEPTH).
module abrsf_front #(
	parameter int ID_BITS = abrsf_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         op,
	input  logic               producer_has_block,
	input  logic [ID_BITS-1:0] producer_block_id,
	input  logic               device_accepts,
	input  logic               push,
	output logic               full,
	output logic               cmd_valid,
	output abrsf_pkg::cmd_t    cmd,
	output logic [ID_BITS-1:0] cmd_pid,
	input  logic               cmd_ready
);
	import abrsf_pkg::*;

	localparam int IDX_W = $clog2(CMD_DEPTH);
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t               ent_q [CMD_DEPTH];
	logic [ID_BITS-1:0] pid_q [CMD_DEPTH];
	logic [IDX_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	op_e_t              op_cls;
	logic               enq, deq;

	// unknown event code is taken and dropped: it causes no result
	always_comb begin
		case (op_e_t'(op))
			OP_START:    op_cls = OP_START;
			OP_COMPLETE: op_cls = OP_COMPLETE;
			OP_STOP:     op_cls = OP_STOP;
			default:     op_cls = OP_NONE;
		endcase
	end

	assign full      = int'(count_q) == CMD_DEPTH;
	assign enq       = push && !full && (op_cls != OP_NONE);
	assign cmd_valid = count_q != '0;
	assign deq       = cmd_valid && cmd_ready;
	assign cmd       = ent_q[head_q];
	assign cmd_pid   = pid_q[head_q];

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
		if (int'(p) == CMD_DEPTH - 1) return '0;
		return IDX_W'(int'(p) + 1);
	endfunction

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[tail_q] <= '{op: op_cls, has: producer_has_block, acc: device_accepts};
			pid_q[tail_q] <= producer_block_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (enq) tail_q <= nxt(tail_q);
			if (deq) head_q <= nxt(head_q);
			if (enq && !deq) count_q <= count_q + CNT_W'(1);
			else if (deq && !enq) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> hw/rtl/abrsf_back.sv
// Back end of the block recycler: sequencer over the pending and pool ring memories.
// Depends on abrsf_pkg (cmd_t, flags_t, sizes) and assert_macros.svh.
module abrsf_back #(
	parameter int MAX_BLOCKS = abrsf_pkg::MAX_BLOCKS_DEF,
	parameter int ID_BITS    = abrsf_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [abrsf_pkg::NB_W-1:0]    depth_cfg,
	input  logic [abrsf_pkg::SID_W-1:0]   silent_block_id,
	input  logic                          cmd_valid,
	input  abrsf_pkg::cmd_t               cmd,
	input  logic [ID_BITS-1:0]            cmd_pid,
	output logic                          cmd_ready,
	output logic                          res_valid,
	input  logic                          res_ready,
	output abrsf_pkg::flags_t             res_flags,
	output logic [abrsf_pkg::POOLED_W-1:0] res_pooled,
	output logic [ID_BITS-1:0]            res_release_id,
	output logic [ID_BITS-1:0]            res_submit_id
);
	import abrsf_pkg::*;

	localparam int PTR_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_CEX,
		B_SLOOP,
		B_SEMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   i_q;
	logic [PTR_W-1:0]   pend_rp_q, pend_wp_q, pool_rp_q, pool_wp_q;
	logic [CNT_W-1:0]   pend_count_q, pool_count_q;
	logic               wait_q, has_q, acc_q, rd_v_q;
	logic [ID_BITS-1:0] pid_q;

	logic [ID_BITS-1:0] pend_mem [MAX_BLOCKS];
	logic [ID_BITS-1:0] pool_mem [MAX_BLOCKS];
	logic [ID_BITS-1:0] pend_rd_q, pool_rd_q;

	logic [CNT_W-1:0]   cap;
	logic [ID_BITS-1:0] silent;
	logic               i_last;
	logic               pend_ok, pool_ok, rel_v, push_ok, c_err;
	logic [CNT_W-1:0]   pend_cnt_pop;
	logic [ID_BITS-1:0] sub_id;
	logic               pend_we, pool_we;
	logic [PTR_W-1:0]   pend_wa;
	logic [ID_BITS-1:0] pend_wd;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
	                                         input logic [CNT_W-1:0] c);
		if (int'(p) + 1 >= int'(c)) return '0;
		return PTR_W'(int'(p) + 1);
	endfunction

	// capacity clamped to 2 .. MAX_BLOCKS
	always_comb begin
		if (int'(depth_cfg) < 2) cap = CNT_W'(2);
		else if (int'(depth_cfg) > MAX_BLOCKS) cap = CNT_W'(MAX_BLOCKS);
		else cap = CNT_W'(depth_cfg);
	end

	assign silent = ID_BITS'(silent_block_id);
	assign i_last = int'(i_q) + 1 == int'(cap);

	// completion: pop pending, pick pool / producer / silent, push if accepted
	assign pend_ok      = pend_count_q != '0;
	assign pool_ok      = pool_count_q != '0;
	assign rel_v        = pend_ok && (pend_rd_q != silent);
	assign sub_id       = pool_ok ? pool_rd_q : (has_q ? pid_q : silent);
	assign pend_cnt_pop = pend_count_q - CNT_W'(pend_ok);
	assign push_ok      = acc_q && (pend_cnt_pop < cap);
	assign c_err        = !pend_ok || (acc_q && !push_ok);

	assign cmd_ready = state_q == B_IDLE;

	always_comb begin
		res_valid      = 1'b0;
		res_flags      = '0;
		res_pooled     = POOLED_W'(pool_count_q);
		res_release_id = '0;
		res_submit_id  = '0;
		case (state_q)
			B_START: begin
				res_valid               = 1'b1;
				res_flags.submit_valid  = 1'b1;
				res_flags.submit_silent = 1'b1;
				res_flags.clear_device  = i_q == '0;
				res_flags.last          = i_last;
				res_submit_id           = silent;
			end
			B_CEX: begin
				res_valid               = 1'b1;
				res_flags.release_valid = rel_v;
				res_flags.submit_valid  = 1'b1;
				res_flags.submit_silent = sub_id == silent;
				res_flags.took_producer = !pool_ok && has_q;
				res_flags.took_pool     = pool_ok;
				res_flags.wait_hint     = !pool_ok && wait_q;
				res_flags.queue_error   = c_err;
				res_flags.last          = 1'b1;
				res_pooled              = POOLED_W'(pool_count_q - CNT_W'(pool_ok));
				res_release_id          = rel_v ? pend_rd_q : '0;
				res_submit_id           = sub_id;
			end
			B_SEMIT: begin
				res_valid              = 1'b1;
				res_flags.clear_device = 1'b1;
				res_flags.last         = 1'b1;
			end
			default: ;
		endcase
	end

	// memory write ports
	always_comb begin
		pend_we = 1'b0;
		pend_wa = pend_wp_q;
		pend_wd = sub_id;
		case (state_q)
			B_START: begin
				pend_we = res_ready;
				pend_wa = i_q[PTR_W-1:0];
				pend_wd = silent;
			end
			B_CEX:   pend_we = res_ready && push_ok;
			default: ;
		endcase
	end

	assign pool_we = (state_q == B_SLOOP) && rd_v_q && (pend_rd_q != silent)
	                 && (pool_count_q < cap);

	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pend_wa] <= pend_wd;
		pend_rd_q <= pend_mem[pend_rp_q];
	end

	always_ff @(posedge clk) begin
		if (pool_we) pool_mem[pool_wp_q] <= pend_rd_q;
		pool_rd_q <= pool_mem[pool_rp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			has_q <= cmd.has;
			acc_q <= cmd.acc;
			pid_q <= cmd_pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			i_q          <= '0;
			pend_rp_q    <= '0;
			pend_wp_q    <= '0;
			pend_count_q <= '0;
			pool_rp_q    <= '0;
			pool_wp_q    <= '0;
			pool_count_q <= '0;
			wait_q       <= 1'b0;
			rd_v_q       <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_START: begin
								i_q       <= '0;
								pend_rp_q <= '0;
								pend_wp_q <= '0;
								wait_q    <= pool_count_q == '0;
								state_q   <= B_START;
							end
							OP_COMPLETE: state_q <= B_CEX;
							OP_STOP: begin
								pool_rp_q    <= '0;
								pool_wp_q    <= '0;
								pool_count_q <= '0;
								rd_v_q       <= 1'b0;
								state_q      <= B_SLOOP;
							end
							default: ;
						endcase
					end
				end
				B_START: begin
					if (res_ready) begin
						if (i_last) begin
							pend_count_q <= cap;
							state_q      <= B_IDLE;
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				B_CEX: begin
					if (res_ready) begin
						if (pend_ok) pend_rp_q <= adv(pend_rp_q, cap);
						if (push_ok) pend_wp_q <= adv(pend_wp_q, cap);
						pend_count_q <= pend_cnt_pop + CNT_W'(push_ok);
						if (pool_ok) pool_rp_q <= adv(pool_rp_q, cap);
						pool_count_q <= pool_count_q - CNT_W'(pool_ok);
						wait_q       <= !pool_ok && !has_q;
						state_q      <= B_IDLE;
					end
				end
				B_SLOOP: begin
					if (pool_we) begin
						pool_wp_q    <= adv(pool_wp_q, cap);
						pool_count_q <= pool_count_q + CNT_W'(1);
					end
					if (pend_ok) begin
						pend_rp_q    <= adv(pend_rp_q, cap);
						pend_count_q <= pend_count_q - CNT_W'(1);
						rd_v_q       <= 1'b1;
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q) state_q <= B_SEMIT;
					end
				end
				B_SEMIT: begin
					if (res_ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_pend_bound, clk, arst_n, int'(pend_count_q) <= MAX_BLOCKS)
	`ASSERT_ALWAYS(a_pool_bound, clk, arst_n, int'(pool_count_q) <= MAX_BLOCKS)
	`ASSERT_IMPLY(a_clear_no_rel, clk, arst_n, res_valid && res_flags.clear_device,
		!res_flags.release_valid && !res_flags.queue_error && !res_flags.took_pool)
	`ASSERT_NEXT(a_stop_drained, clk, arst_n,
		state_q == B_SLOOP && !pend_ok && !rd_v_q, state_q == B_SEMIT)

endmodule

>>> hw/rtl/audio_block_recycler_silence_fill.sv
// Top level of the audio block recycler with silence fill.
// Depends on abrsf_pkg, abrsf_front, abrsf_back and abrsf_res_fifo.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  request   | push / full        | op, producer_has_block, producer_block_id,
//            |                    | device_accepts
//  result    | empty / pop        | release_*, submit_*, took_*, wait_hint,
//            |                    | clear_device, queue_error, pooled_count, last
//  config    | wr_en (no wait)    | wr_index, wr_data
//
// Sequence: a request is registered in the front queue, then the back-end sequencer
//  runs it: completion as one result; start as cap silent submissions, one per cycle
//  while the result queue has room; stop drains one pending entry per cycle.
// Reset: arst_n clears all pointers, counts, waiting flag and config (playback depth 2);
//  the ring memories are not cleared and need no clearing pass.
// Stalls: the front takes up to two further requests while the back works; the back
//  holds when the two-entry result queue is full, and full rises when the front fills.
module audio_block_recycler_silence_fill #(
	parameter int MAX_BLOCKS = abrsf_pkg::MAX_BLOCKS_DEF,
	parameter int ID_BITS    = abrsf_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    op,
	input  logic                          producer_has_block,
	input  logic [ID_BITS-1:0]            producer_block_id,
	input  logic                          device_accepts,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic                          release_valid,
	output logic [ID_BITS-1:0]            release_id,
	output logic                          submit_valid,
	output logic [ID_BITS-1:0]            submit_id,
	output logic                          submit_silent,
	output logic                          took_producer,
	output logic                          took_pool,
	output logic                          wait_hint,
	output logic                          clear_device,
	output logic                          queue_error,
	output logic [abrsf_pkg::POOLED_W-1:0] pooled_count,
	output logic                          last,
	// configuration
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [abrsf_pkg::SID_W-1:0]   wr_data
);
	import abrsf_pkg::*;

	localparam int RES_W = $bits(flags_t) + POOLED_W + 2 * ID_BITS;

	logic [NB_W-1:0]    depth_q;
	logic [SID_W-1:0]   silent_q;

	logic               cmd_valid, cmd_ready;
	cmd_t               cmd;
	logic [ID_BITS-1:0] cmd_pid;

	logic               res_valid, res_ready;
	flags_t             res_flags, out_flags;
	logic [POOLED_W-1:0] res_pooled;
	logic [ID_BITS-1:0] res_release_id, res_submit_id;
	logic [RES_W-1:0]   res_data, out_data;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= NB_W'(2);
			silent_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEPTH:     depth_q  <= wr_data[NB_W-1:0];
				REG_SILENT_ID: silent_q <= wr_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify requests, two-deep command queue
	abrsf_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.op                 (op),
		.producer_has_block (producer_has_block),
		.producer_block_id  (producer_block_id),
		.device_accepts     (device_accepts),
		.push               (push),
		.full               (full),
		.cmd_valid          (cmd_valid),
		.cmd                (cmd),
		.cmd_pid            (cmd_pid),
		.cmd_ready          (cmd_ready)
	);

	// back: ring memories and the event sequencer
	abrsf_back #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.ID_BITS   (ID_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.depth_cfg       (depth_q),
		.silent_block_id (silent_q),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pid         (cmd_pid),
		.cmd_ready       (cmd_ready),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res_flags       (res_flags),
		.res_pooled      (res_pooled),
		.res_release_id  (res_release_id),
		.res_submit_id   (res_submit_id)
	);

	assign res_data = {res_flags, res_pooled, res_release_id, res_submit_id};

	// result queue decouples the sequencer from the consumer
	abrsf_res_fifo #(
		.WIDTH(RES_W)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_ready (res_ready),
		.wr_data  (res_data),
		.empty    (empty),
		.pop      (pop),
		.rd_data  (out_data)
	);

	assign {out_flags, pooled_count, release_id, submit_id} = out_data;

	assign release_valid = out_flags.release_valid;
	assign submit_valid  = out_flags.submit_valid;
	assign submit_silent = out_flags.submit_silent;
	assign took_producer = out_flags.took_producer;
	assign took_pool     = out_flags.took_pool;
	assign wait_hint     = out_flags.wait_hint;
	assign clear_device  = out_flags.clear_device;
	assign queue_error   = out_flags.queue_error;
	assign last          = out_flags.last;

endmodule
